@@ hw/rtl/bpps_pkg.sv @@
// Shared constants, types and the reciprocal table for the parallel path set unit.
package bpps_pkg;

  localparam int unsigned MaxDigitsDef = 4;
  localparam int unsigned MaxRadixDef  = 16;

  localparam int unsigned IdW        = 16;
  localparam int unsigned SwW        = 17;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned OffW       = 4;
  localparam int unsigned NumOffs    = 4;
  localparam int unsigned PathW      = 2;
  localparam int unsigned HopW       = 3;
  localparam int unsigned RecipShift = 21;
  localparam int unsigned RecipW     = 21;

  localparam logic [RadixW-1:0] RadixRst = RadixW'(4);
  localparam logic [LevelW-1:0] LevelRst = LevelW'(1);

  typedef enum logic {
    CfgRadix    = 1'b0,
    CfgTopLevel = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic              tag;
    logic [IdW-1:0]    num;
    logic [RadixW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              tag;
    logic [IdW-1:0]    quo;
    logic [RadixW-1:0] rem;
  } div_rsp_t;

  // Floor of 2^21 / den for every legal digit base.
  function automatic logic [RecipW-1:0] recip(input logic [RadixW-1:0] den);
    logic [RecipW-1:0] m;
    case (den)
      RadixW'(2):  m = RecipW'(1048576);
      RadixW'(3):  m = RecipW'(699050);
      RadixW'(4):  m = RecipW'(524288);
      RadixW'(5):  m = RecipW'(419430);
      RadixW'(6):  m = RecipW'(349525);
      RadixW'(7):  m = RecipW'(299593);
      RadixW'(8):  m = RecipW'(262144);
      RadixW'(9):  m = RecipW'(233016);
      RadixW'(10): m = RecipW'(209715);
      RadixW'(11): m = RecipW'(190650);
      RadixW'(12): m = RecipW'(174762);
      RadixW'(13): m = RecipW'(161319);
      RadixW'(14): m = RecipW'(149796);
      RadixW'(15): m = RecipW'(139810);
      RadixW'(16): m = RecipW'(131072);
      default:     m = RecipW'(1048576);
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/bpps_div.sv @@
// Two-stage divider by a small digit base using a reciprocal multiply and one correction.
module bpps_div
  import bpps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned ProdW = IdW + RecipW;
  localparam int unsigned QnW   = IdW + RadixW;

  logic              s1_vld_q;
  logic              s1_tag_q;
  logic [IdW-1:0]    s1_num_q;
  logic [RadixW-1:0] s1_den_q;
  logic [ProdW-1:0]  s1_prod_q;

  logic [IdW-1:0]    q0;
  logic [QnW-1:0]    qn;
  logic [IdW-1:0]    r_raw;
  logic              fix;

  logic              rsp_done_q;
  logic              rsp_tag_q;
  logic [IdW-1:0]    rsp_quo_q;
  logic [RadixW-1:0] rsp_rem_q;

  assign q0    = s1_prod_q[RecipShift +: IdW];
  assign qn    = QnW'(q0) * QnW'(s1_den_q);
  assign r_raw = s1_num_q - qn[IdW-1:0];
  assign fix   = (r_raw >= IdW'(s1_den_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      rsp_done_q <= 1'b0;
    end else begin
      s1_vld_q   <= req_i.start;
      rsp_done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q  <= req_i.tag;
    s1_num_q  <= req_i.num;
    s1_den_q  <= req_i.den;
    s1_prod_q <= ProdW'(req_i.num) * ProdW'(recip(req_i.den));
    rsp_tag_q <= s1_tag_q;
    if (fix) begin
      rsp_quo_q <= q0 + IdW'(1);
      rsp_rem_q <= RadixW'(r_raw - IdW'(s1_den_q));
    end else begin
      rsp_quo_q <= q0;
      rsp_rem_q <= RadixW'(r_raw);
    end
  end

  assign rsp_o = '{done: rsp_done_q, tag: rsp_tag_q, quo: rsp_quo_q, rem: rsp_rem_q};

endmodule

@@ hw/rtl/bcube_parallel_path_set_unit.sv @@
// Top level: builds the parallel path set between two server ids, one hop per transfer.
// The first hop waits until both ids are split into digits, the two ids sharing the
// two-stage divider one digit at a time. A new item is accepted only after every hop
// of the last one is issued; hops wait while the output is stalled.
// Reset clears control state and sets radix 4 and top level 1; there is no clearing pass.
module bcube_parallel_path_set_unit
  import bpps_pkg::*;
#(
  parameter int unsigned MaxDigits = MaxDigitsDef,
  parameter int unsigned MaxRadix  = MaxRadixDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [RadixW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IdW-1:0]    src_server_i,
  input  logic [IdW-1:0]    dst_server_i,
  input  logic [OffW-1:0]   offset_pos0_i,
  input  logic [OffW-1:0]   offset_pos1_i,
  input  logic [OffW-1:0]   offset_pos2_i,
  input  logic [OffW-1:0]   offset_pos3_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PathW-1:0]  path_index_o,
  output logic [HopW-1:0]   hop_index_o,
  output logic [SwW-1:0]    switch_tag_o,
  output logic [IdW-1:0]    server_id_o,
  output logic              path_end_o,
  output logic              last_o
);

  localparam int unsigned DigW  = $clog2(MaxRadix);
  localparam int unsigned PosW  = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int unsigned PosW1 = PosW + 1;

  typedef enum logic [2:0] {
    StIdle,
    StSplit,
    StPathInit,
    StDetour,
    StScan
  } state_e;

  state_e            state_q;
  logic [RadixW-1:0] radix_q;
  logic [LevelW-1:0] level_q;

  logic [DigW-1:0]   a_q   [MaxDigits];
  logic [DigW-1:0]   b_q   [MaxDigits];
  logic [DigW-1:0]   cur_q [MaxDigits];
  logic [DigW-1:0]   off_q [MaxDigits];
  logic [SwW-1:0]    w_q   [MaxDigits];
  logic [SwW-1:0]    wsh   [MaxDigits];
  logic [SwW-1:0]    powk1_q;
  logic [SwW-1:0]    pw_q;
  logic [SwW-1:0]    pw_n;
  logic [PosW-1:0]   pcnt_q;
  logic              pow_done_q;
  logic [IdW-1:0]    dst_q;
  logic              first_q;
  logic [PosW-1:0]   dps_q;
  logic [PosW-1:0]   dpd_q;
  logic              sdone_q;
  logic              ddone_q;
  logic [PosW-1:0]   pos_q;
  logic [PosW-1:0]   p_q;
  logic [PosW-1:0]   rcnt_q;
  logic [PathW-1:0]  pidx_q;
  logic [HopW-1:0]   hop_q;

  logic              out_valid_q;
  logic [PathW-1:0]  out_path_q;
  logic [HopW-1:0]   out_hop_q;
  logic [SwW-1:0]    out_sw_q;
  logic [IdW-1:0]    out_srv_q;
  logic              out_pend_q;
  logic              out_last_q;

  logic [RadixW-1:0] n_eff;
  logic [PosW-1:0]   k_eff;
  logic [OffW-1:0]   off_raw [NumOffs];
  logic [DigW-1:0]   off_clamp [MaxDigits];
  logic [RadixW-1:0] det_sum;
  logic [DigW-1:0]   det_dig;
  logic [PosW-1:0]   hop_p;
  logic [DigW-1:0]   hop_d;
  logic [PosW-1:0]   layer;
  logic [SwW-1:0]    srv_sum;
  logic [SwW-1:0]    sw_sum;
  logic [SwW-1:0]    switch_val;
  logic [PosW1-1:0]  ahead [MaxDigits];
  logic              rem_any;
  logic              need;
  logic              emit;
  logic              slot_free;
  logic              emit_end;
  logic [PosW-1:0]   p_next;
  logic              split_more;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  bpps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (radix_q < RadixW'(2)) begin
      n_eff = RadixW'(2);
    end else if (int'(radix_q) > MaxRadix) begin
      n_eff = RadixW'(MaxRadix);
    end else begin
      n_eff = radix_q;
    end
    if (int'(level_q) > MaxDigits - 1) begin
      k_eff = PosW'(MaxDigits - 1);
    end else begin
      k_eff = PosW'(level_q);
    end
  end

  assign off_raw[0] = offset_pos0_i;
  assign off_raw[1] = offset_pos1_i;
  assign off_raw[2] = offset_pos2_i;
  assign off_raw[3] = offset_pos3_i;

  always_comb begin
    for (int j = 0; j < MaxDigits; j++) begin
      off_clamp[j] = DigW'(1);
      if (j < NumOffs) begin
        if (off_raw[j % NumOffs] == '0) begin
          off_clamp[j] = DigW'(1);
        end else if (RadixW'(off_raw[j % NumOffs]) > n_eff - RadixW'(1)) begin
          off_clamp[j] = DigW'(n_eff - RadixW'(1));
        end else begin
          off_clamp[j] = DigW'(off_raw[j % NumOffs]);
        end
      end
    end
  end

  // Shared divider requests: source first, destination in the next cycle, then each
  // quotient goes straight back in until all k+1 digits of that id are out.
  always_comb begin
    split_more = div_rsp.tag ? (dpd_q != '0) : (dps_q != '0);
    div_req       = '0;
    div_req.den   = n_eff;
    if (state_q == StIdle && in_valid_i) begin
      div_req.start = 1'b1;
      div_req.tag   = 1'b0;
      div_req.num   = src_server_i;
    end else if (state_q == StSplit && first_q) begin
      div_req.start = 1'b1;
      div_req.tag   = 1'b1;
      div_req.num   = dst_q;
    end else if (state_q == StSplit && div_rsp.done && split_more) begin
      div_req.start = 1'b1;
      div_req.tag   = div_rsp.tag;
      div_req.num   = div_rsp.quo;
    end
  end

  assign pw_n = SwW'(pw_q * SwW'(n_eff));

  assign det_sum = RadixW'(cur_q[pos_q]) + RadixW'(off_q[pos_q]);
  assign det_dig = (det_sum >= n_eff) ? DigW'(det_sum - n_eff) : DigW'(det_sum);

  assign need   = (cur_q[p_q] != b_q[p_q]);
  assign p_next = (p_q == '0) ? k_eff : p_q - PosW'(1);

  always_comb begin
    if (state_q == StDetour) begin
      hop_p = pos_q;
      hop_d = det_dig;
    end else begin
      hop_p = p_q;
      hop_d = b_q[p_q];
    end
  end

  always_comb begin
    for (int j = 0; j < MaxDigits; j++) begin
      wsh[j] = (j + 1 < MaxDigits) ? w_q[(j + 1) % MaxDigits] : '0;
    end
  end

  // Server id of the hop's target and the switch number from the unchanged digits.
  always_comb begin
    srv_sum = '0;
    sw_sum  = '0;
    for (int j = 0; j < MaxDigits; j++) begin
      if (PosW'(j) == hop_p) begin
        srv_sum = srv_sum + SwW'(SwW'(hop_d) * w_q[j]);
      end else begin
        srv_sum = srv_sum + SwW'(SwW'(cur_q[j]) * w_q[j]);
      end
      if (PosW'(j) < hop_p) begin
        sw_sum = sw_sum + SwW'(SwW'(cur_q[j]) * wsh[j]);
      end else if (PosW'(j) > hop_p) begin
        sw_sum = sw_sum + SwW'(SwW'(cur_q[j]) * w_q[j]);
      end
    end
  end

  assign layer      = k_eff - hop_p;
  assign switch_val = powk1_q + SwW'(SwW'(layer) * w_q[0]) + sw_sum;

  // A hop ends its path when no position still to be visited differs.
  always_comb begin
    rem_any = 1'b0;
    for (int q = 0; q < MaxDigits; q++) begin
      if ({1'b0, p_q} >= PosW1'(q)) begin
        ahead[q] = {1'b0, p_q} - PosW1'(q);
      end else begin
        ahead[q] = {1'b0, p_q} + {1'b0, k_eff} + PosW1'(1) - PosW1'(q);
      end
      if (PosW1'(q) <= {1'b0, k_eff} && ahead[q] != '0 && ahead[q] <= {1'b0, rcnt_q} &&
          cur_q[q] != b_q[q]) begin
        rem_any = 1'b1;
      end
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == StDetour) || (state_q == StScan && need);
  assign emit_end  = (state_q == StScan) && !rem_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixRst;
      level_q <= LevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgRadix:    radix_q <= cfg_data_i;
        CfgTopLevel: level_q <= cfg_data_i[LevelW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      sdone_q     <= 1'b0;
      ddone_q     <= 1'b0;
      pow_done_q  <= 1'b0;
    end else begin
      if (emit && slot_free) begin
        out_valid_q <= 1'b1;
        out_path_q  <= pidx_q;
        out_hop_q   <= hop_q;
        out_sw_q    <= switch_val;
        out_srv_q   <= srv_sum[IdW-1:0];
        out_pend_q  <= emit_end;
        out_last_q  <= emit_end && (pos_q == '0);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            dst_q      <= dst_server_i;
            first_q    <= 1'b1;
            dps_q      <= k_eff;
            dpd_q      <= k_eff;
            sdone_q    <= 1'b0;
            ddone_q    <= 1'b0;
            pw_q       <= SwW'(1);
            pcnt_q     <= k_eff;
            pow_done_q <= 1'b0;
            for (int j = 0; j < MaxDigits; j++) begin
              a_q[j]   <= '0;
              b_q[j]   <= '0;
              w_q[j]   <= '0;
              off_q[j] <= off_clamp[j];
            end
            state_q <= StSplit;
          end
        end
        StSplit: begin
          first_q <= 1'b0;
          if (!pow_done_q) begin
            w_q[pcnt_q] <= pw_q;
            if (pcnt_q == '0) begin
              powk1_q    <= pw_n;
              pow_done_q <= 1'b1;
            end else begin
              pcnt_q <= pcnt_q - PosW'(1);
              pw_q   <= pw_n;
            end
          end
          if (div_rsp.done) begin
            if (div_rsp.tag) begin
              b_q[dpd_q] <= DigW'(div_rsp.rem);
              if (dpd_q == '0) begin
                ddone_q <= 1'b1;
              end else begin
                dpd_q <= dpd_q - PosW'(1);
              end
            end else begin
              a_q[dps_q] <= DigW'(div_rsp.rem);
              if (dps_q == '0) begin
                sdone_q <= 1'b1;
              end else begin
                dps_q <= dps_q - PosW'(1);
              end
            end
          end
          if (sdone_q && ddone_q && pow_done_q) begin
            pos_q   <= k_eff;
            pidx_q  <= '0;
            state_q <= StPathInit;
          end
        end
        StPathInit: begin
          for (int j = 0; j < MaxDigits; j++) begin
            cur_q[j] <= a_q[j];
          end
          hop_q <= '0;
          if (a_q[pos_q] != b_q[pos_q]) begin
            p_q     <= pos_q;
            rcnt_q  <= k_eff;
            state_q <= StScan;
          end else begin
            state_q <= StDetour;
          end
        end
        StDetour: begin
          if (slot_free) begin
            cur_q[pos_q] <= det_dig;
            hop_q        <= hop_q + HopW'(1);
            p_q          <= (pos_q == '0) ? k_eff : pos_q - PosW'(1);
            rcnt_q       <= k_eff;
            state_q      <= StScan;
          end
        end
        StScan: begin
          if (!need || slot_free) begin
            if (need) begin
              cur_q[p_q] <= b_q[p_q];
              hop_q      <= hop_q + HopW'(1);
            end
            if (rcnt_q == '0) begin
              if (pos_q == '0) begin
                state_q <= StIdle;
              end else begin
                pos_q   <= pos_q - PosW'(1);
                pidx_q  <= pidx_q + PathW'(1);
                state_q <= StPathInit;
              end
            end else begin
              p_q    <= p_next;
              rcnt_q <= rcnt_q - PosW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign path_index_o = out_path_q;
  assign hop_index_o  = out_hop_q;
  assign switch_tag_o = out_sw_q;
  assign server_id_o  = out_srv_q;
  assign path_end_o   = out_pend_q;
  assign last_o       = out_last_q;

endmodule

@@ hw/rtl/bpps_checker.sv @@
// Port-level checks for the parallel path set unit and the bind that attaches them.
module bpps_port_sva
  import bpps_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [SwW-1:0]   switch_tag_i,
  input logic [IdW-1:0]   server_id_i,
  input logic             path_end_i,
  input logic             last_i
);

  // An accepted item keeps the unit busy at least for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input accepted again right after a transfer");

  // The final hop of the set also closes its path.
  a_last_ends_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> path_end_i)
    else $error("last hop without path end");

  // While a hop other than the final one waits, the unit still owns the item.
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> in_stall_i)
    else $error("new item could be accepted before the path set finished");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      out_valid_i && $stable(switch_tag_i) && $stable(server_id_i))
    else $error("stalled hop changed");

endmodule

bind bcube_parallel_path_set_unit bpps_port_sva u_bpps_port_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .switch_tag_i (switch_tag_o),
  .server_id_i  (server_id_o),
  .path_end_i   (path_end_o),
  .last_i       (last_o)
);

@@ test/bpps_checker.sv @@
// Checker for the parallel path set unit: predicts every hop of each query and compares it.
module bpps_checker
  import bpps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [RadixW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [IdW-1:0]    src_server_i,
  input  logic [IdW-1:0]    dst_server_i,
  input  logic [OffW-1:0]   offset_pos0_i,
  input  logic [OffW-1:0]   offset_pos1_i,
  input  logic [OffW-1:0]   offset_pos2_i,
  input  logic [OffW-1:0]   offset_pos3_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [PathW-1:0]  path_index_i,
  input  logic [HopW-1:0]   hop_index_i,
  input  logic [SwW-1:0]    switch_tag_i,
  input  logic [IdW-1:0]    server_id_i,
  input  logic              path_end_i,
  input  logic              last_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o,
  output int unsigned       hops_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef int unsigned digits_t [MaxDigitsDef];

  typedef struct packed {
    logic [PathW-1:0] path_index;
    logic [HopW-1:0]  hop_index;
    logic [SwW-1:0]   switch_tag;
    logic [IdW-1:0]   server_id;
    logic             path_end;
    logic             last;
  } hop_t;

  logic [RadixW-1:0] radix_q;
  logic [LevelW-1:0] level_q;
  hop_t              expected_hops[$];
  int unsigned       fails = 0;
  int unsigned       hops_seen = 0;

  function automatic digits_t split_id(input int unsigned v, input int unsigned n,
                                       input int unsigned nd);
    digits_t     d;
    int unsigned j;
    d = '{default: 0};
    for (j = nd; j > 0; j--) begin
      d[j-1] = v % n;
      v = v / n;
    end
    return d;
  endfunction

  function automatic hop_t hop_between(input int unsigned path, input int unsigned hop,
                                       input digits_t from_d, input digits_t to_d,
                                       input int unsigned n, input int unsigned k,
                                       input int unsigned pw_k, input int unsigned pw_k1);
    hop_t        h;
    int unsigned j, layer, sw, srv;
    layer = 0;
    sw    = 0;
    srv   = 0;
    for (j = 0; j <= k; j++) begin
      if (from_d[j] == to_d[j]) begin
        sw = sw * n + from_d[j];
      end else begin
        layer = k - j;
      end
      srv = srv * n + to_d[j];
    end
    h.path_index = PathW'(path);
    h.hop_index  = HopW'(hop);
    h.switch_tag = SwW'(pw_k1 + layer * pw_k + sw);
    h.server_id  = IdW'(srv);
    h.path_end   = 1'b0;
    h.last       = 1'b0;
    return h;
  endfunction

  // One path per digit position, from the top level down; every path starts at the source.
  function automatic void build_path_set(input logic [IdW-1:0] src, input logic [IdW-1:0] dst,
                                         input logic [NumOffs-1:0][OffW-1:0] offs);
    int unsigned n, k, nd, pw_k, pw_k1, base, idx, p, off, hop, pidx;
    int          i;
    digits_t     sd, dd, cur, nxt;
    hop_t        hops[$];
    n = radix_q;
    if (n < 2) n = 2;
    if (n > MaxRadixDef) n = MaxRadixDef;
    k = level_q;
    if (k > MaxDigitsDef - 1) k = MaxDigitsDef - 1;
    nd   = k + 1;
    pw_k = 1;
    for (idx = 0; idx < k; idx++) pw_k = pw_k * n;
    pw_k1 = pw_k * n;
    sd    = split_id(src, n, nd);
    dd    = split_id(dst, n, nd);
    pidx  = 0;
    for (i = int'(k); i >= 0; i--) begin
      cur = sd;
      hop = 0;
      if (sd[i] != dd[i]) begin
        base = i + 1;
      end else begin
        // Matching digit: detour through a neighbor first.
        off = offs[i];
        if (off < 1) off = 1;
        if (off > n - 1) off = n - 1;
        nxt    = cur;
        nxt[i] = (sd[i] + off) % n;
        hops.insert(hops.size(), hop_between(pidx, hop, cur, nxt, n, k, pw_k, pw_k1));
        hop++;
        cur  = nxt;
        base = i;
      end
      for (idx = nd; idx > 0; idx--) begin
        p = (base + idx - 1) % nd;
        if (cur[p] != dd[p]) begin
          nxt    = cur;
          nxt[p] = dd[p];
          hops.insert(hops.size(), hop_between(pidx, hop, cur, nxt, n, k, pw_k, pw_k1));
          hop++;
          cur = nxt;
        end
      end
      hops[hops.size() - 1].path_end = 1'b1;
      pidx++;
    end
    hops[hops.size() - 1].last = 1'b1;
    foreach (hops[j]) expected_hops.insert(expected_hops.size(), hops[j]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hop_t want;
    if (!rst_ni) begin
      radix_q = RadixRst;
      level_q = LevelRst;
      expected_hops.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        hops_seen++;
        if (expected_hops.size() == 0) begin
          $error("hop transfer with nothing expected: path %0d hop %0d server %0d",
                 path_index_i, hop_index_i, server_id_i);
          fails++;
        end else begin
          want = expected_hops.pop_front();
          if (path_index_i !== want.path_index) begin
            $error("path_index: expected %0d, got %0d", want.path_index, path_index_i);
            fails++;
          end
          if (hop_index_i !== want.hop_index) begin
            $error("hop_index: expected %0d, got %0d", want.hop_index, hop_index_i);
            fails++;
          end
          if (switch_tag_i !== want.switch_tag) begin
            $error("switch_tag: expected %0d, got %0d", want.switch_tag, switch_tag_i);
            fails++;
          end
          if (server_id_i !== want.server_id) begin
            $error("server_id: expected %0d, got %0d", want.server_id, server_id_i);
            fails++;
          end
          if (path_end_i !== want.path_end) begin
            $error("path_end: expected %0d, got %0d", want.path_end, path_end_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        build_path_set(src_server_i, dst_server_i,
                       {offset_pos3_i, offset_pos2_i, offset_pos1_i, offset_pos0_i});
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgRadix) begin
          radix_q = cfg_data_i;
        end else begin
          level_q = cfg_data_i[LevelW-1:0];
        end
      end
    end
    pending_o   <= expected_hops.size();
    fail_cnt_o  <= fails;
    hops_seen_o <= hops_seen;
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top: drives path queries and register settings into the parallel path set unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpps_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned RandomItems = 175;
  localparam int unsigned SettlePause = 16;
  localparam int unsigned DrainPause  = 40;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_index_i   = 1'b0;
  logic [RadixW-1:0] cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [IdW-1:0]    src_server_i  = '0;
  logic [IdW-1:0]    dst_server_i  = '0;
  logic [OffW-1:0]   offset_pos0_i = '0;
  logic [OffW-1:0]   offset_pos1_i = '0;
  logic [OffW-1:0]   offset_pos2_i = '0;
  logic [OffW-1:0]   offset_pos3_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [PathW-1:0]  path_index_o;
  logic [HopW-1:0]   hop_index_o;
  logic [SwW-1:0]    switch_tag_o;
  logic [IdW-1:0]    server_id_o;
  logic              path_end_o;
  logic              last_o;

  int unsigned       fail_cnt;
  int unsigned       pending_hops;
  int unsigned       hops_seen;
  int unsigned       cycle_cnt   = 0;
  int unsigned       query_cnt   = 0;
  int unsigned       setting_cnt = 0;
  int unsigned       stall_hold  = 0;
  int unsigned       stall_run;
  logic [RadixW-1:0] cur_radix   = RadixRst;
  logic [LevelW-1:0] cur_level   = LevelRst;
  bit                burst_phase = 1'b0;

  always #5 clk_i = ~clk_i;

  bcube_parallel_path_set_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .src_server_i (src_server_i),
    .dst_server_i (dst_server_i),
    .offset_pos0_i(offset_pos0_i),
    .offset_pos1_i(offset_pos1_i),
    .offset_pos2_i(offset_pos2_i),
    .offset_pos3_i(offset_pos3_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_index_o (path_index_o),
    .hop_index_o  (hop_index_o),
    .switch_tag_o (switch_tag_o),
    .server_id_o  (server_id_o),
    .path_end_o   (path_end_o),
    .last_o       (last_o)
  );

  bpps_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .src_server_i (src_server_i),
    .dst_server_i (dst_server_i),
    .offset_pos0_i(offset_pos0_i),
    .offset_pos1_i(offset_pos1_i),
    .offset_pos2_i(offset_pos2_i),
    .offset_pos3_i(offset_pos3_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_index_i (path_index_o),
    .hop_index_i  (hop_index_o),
    .switch_tag_i (switch_tag_o),
    .server_id_i  (server_id_o),
    .path_end_i   (path_end_o),
    .last_i       (last_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_hops),
    .hops_seen_o  (hops_seen)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The output stall alternates between stalled runs and free runs, some of them long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_run = out_stall_i ? 0 : idle_len();
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_hold  <= stall_run - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_hold  <= ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_hops != 0);
  endtask

  task automatic write_config(input logic [RadixW-1:0] radix, input logic [LevelW-1:0] level);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettlePause) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgRadix;
    cfg_data_i  <= radix;
    @(posedge clk_i);
    cfg_index_i <= CfgTopLevel;
    cfg_data_i  <= {(RadixW - LevelW)'($urandom), level};
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_radix = radix;
    cur_level = level;
    setting_cnt++;
  endtask

  // Offsets are packed with position 3 in the top nibble.
  task automatic send_query(input logic [IdW-1:0] src, input logic [IdW-1:0] dst,
                            input logic [NumOffs*OffW-1:0] offs);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    src_server_i <= src;
    dst_server_i <= dst;
    {offset_pos3_i, offset_pos2_i, offset_pos1_i, offset_pos0_i} <= offs;
    do @(posedge clk_i); while (in_stall_o);
    query_cnt++;
    gap = burst_phase ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned n, nd, pick, sd, dd, s_id, d_id, target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: radix 4, top level 1.
    send_query(16'd0, 16'd0, 16'h0000);
    send_query(16'd5, 16'd5, 16'hFFFF);
    send_query(16'd0, 16'd15, 16'h1111);
    send_query(16'd1, 16'd13, 16'h0020);
    send_query(16'hFFFF, 16'h0000, 16'h3333);
    send_query(16'hAAAA, 16'h5555, 16'h0000);

    write_config(5'd16, 2'd3);
    send_query(16'h0000, 16'hFFFF, 16'h0000);
    send_query(16'h1234, 16'h1234, 16'hF087);
    send_query(16'h1204, 16'h1294, 16'h5A5A);
    send_query(16'hFFFF, 16'hFFFF, 16'hFFFF);

    write_config(5'd2, 2'd0);
    send_query(16'd0, 16'd1, 16'h0000);
    send_query(16'd3, 16'd5, 16'h000F);

    // Radix values below two and above sixteen are clamped by the block.
    write_config(5'd0, 2'd3);
    send_query(16'h000F, 16'h000A, 16'h1234);
    send_query(16'd7, 16'd7, 16'h0000);

    write_config(5'd31, 2'd2);
    send_query(16'h0ABC, 16'h0A0C, 16'h0F00);
    send_query(16'hFFFF, 16'h0000, 16'hFFFF);

    write_config(5'd1, 2'd3);
    send_query(16'hFFFF, 16'h0005, 16'h8421);

    write_config(5'd3, 2'd2);
    send_query(16'd26, 16'd0, 16'h0000);
    send_query(16'd13, 16'd13, 16'h2222);

    target = query_cnt + RandomItems;
    while (query_cnt < target) begin
      write_config(($urandom_range(0, 7) == 0) ? RadixW'($urandom_range(0, 31))
                                               : RadixW'($urandom_range(2, 16)),
                   LevelW'($urandom_range(0, 3)));
      burst_phase = ($urandom_range(0, 3) == 0);
      n  = (cur_radix < 2) ? 2 : (cur_radix > MaxRadixDef) ? MaxRadixDef : cur_radix;
      nd = cur_level + 1;
      repeat ($urandom_range(10, 30)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          s_id = $urandom_range(0, 65535);
          d_id = $urandom_range(0, 65535);
        end else begin
          // Most queries share a random subset of digits, so both path kinds show up.
          s_id = 0;
          d_id = 0;
          repeat (nd) begin
            sd   = $urandom_range(0, n - 1);
            dd   = $urandom_range(0, 1) ? sd : $urandom_range(0, n - 1);
            s_id = s_id * n + sd;
            d_id = d_id * n + dd;
          end
          if (pick == 1) d_id = s_id;
        end
        send_query(IdW'(s_id), IdW'(d_id), 16'($urandom_range(0, 65535)));
      end
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DrainPause) @(posedge clk_i);
    $display("Checked %0d hops from %0d path queries over %0d register settings,",
             hops_seen, query_cnt, setting_cnt);
    $display("with random gaps on the query side and random stalls on the hop side.");
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
